### rtl/es2cal_pkg.sv
// Shared types and constants for the epoch seconds to calendar converter.
`default_nettype none
package es2cal_pkg;

  // Input word: one timestamp and its conversion mode.
  typedef struct packed {
    logic [31:0] seconds_since_epoch;
    logic        use_local;
  } in_word_t;

  // Output word: broken-down calendar time.
  typedef struct packed {
    logic [5:0] second;
    logic [5:0] minute;
    logic [4:0] hour;
    logic [4:0] day_of_month;
    logic [3:0] month;
    logic [7:0] years_since_1900;
    logic [2:0] weekday;
    logic [8:0] day_of_year;
    logic       range_clipped;
  } out_word_t;

  // Calendar constants.
  localparam logic [7:0]  BASE_YEAR       = 8'd70;
  localparam logic [15:0] HOURS_PER_4YEAR = 16'd35064;
  localparam logic [15:0] YEAR1_START     = 16'd8760;
  localparam logic [15:0] YEAR2_START     = 16'd17520;
  localparam logic [15:0] YEAR3_START     = 16'd26304;
  localparam logic [2:0]  EPOCH_WEEKDAY   = 3'd4;
  localparam logic [8:0]  FEB29_YDAY      = 9'd59;
  localparam logic [1:0]  LEAP_YEAR_SLOT  = 2'd2;

  // Day of year at which each month starts in a common year.
  localparam logic [8:0] MONTH_START [12] = '{
    9'd0, 9'd31, 9'd59, 9'd90, 9'd120, 9'd151,
    9'd181, 9'd212, 9'd243, 9'd273, 9'd304, 9'd334
  };

  // Reciprocal constants for exact division by constants.
  // Quotient = (x * M) >> K with K = input bits + ceil(log2 divisor).
  localparam int unsigned     K_DIV15_30 = 34;
  localparam logic [30:0]     M_DIV15_30 = 31'(((64'd1 << 34) + 64'd14) / 64'd15);
  localparam int unsigned     K_DIV15_25 = 29;
  localparam logic [25:0]     M_DIV15_25 = 26'(((64'd1 << 29) + 64'd14) / 64'd15);
  localparam int unsigned     K_DIV3_18  = 20;
  localparam logic [18:0]     M_DIV3_18  = 19'(((64'd1 << 20) + 64'd2) / 64'd3);
  localparam int unsigned     K_DIV4383  = 31;
  localparam logic [18:0]     M_DIV4383  = 19'(((64'd1 << 31) + 64'd4382) / 64'd4383);
  localparam int unsigned     K_DIV7_17  = 20;
  localparam logic [17:0]     M_DIV7_17  = 18'(((64'd1 << 20) + 64'd6) / 64'd7);
  localparam int unsigned     K_DIV3_11  = 13;
  localparam logic [11:0]     M_DIV3_11  = 12'(((64'd1 << 13) + 64'd2) / 64'd3);

endpackage
`default_nettype wire

### rtl/epoch_seconds_to_calendar.sv
// Pipelined converter from epoch seconds to calendar fields.
//
// Channel   Direction  Signals                   Handshake
// config    in         cfg_we, cfg_wdata         written when cfg_we is high
// command   in         start, item, busy         word taken when start & !busy
// result    out        done, result              word valid for the one cycle done is high
//
// Eight register stages; a new word may start in every cycle. The depth is
// set by the chain of reciprocal multiplies (divide by 60, 60, 24 and
// 35064) and the month search.
// busy is never raised, and the receiver cannot hold results off.
// Synchronous reset clears the valid bits and sets the zone offset to zero.
`default_nettype none
module epoch_seconds_to_calendar (
  input  wire                     clk,
  input  wire                     rst,
  input  wire                     cfg_we,
  input  wire logic signed [16:0] cfg_wdata,
  input  wire                     start,
  input  es2cal_pkg::in_word_t    item,
  output logic                    busy,
  output logic                    done,
  output es2cal_pkg::out_word_t   result
);
  import es2cal_pkg::*;

  // Zone offset register.
  logic signed [16:0] zone_offset;

  always_ff @(posedge clk) begin
    if (rst) begin
      zone_offset <= '0;
    end else if (cfg_we) begin
      zone_offset <= cfg_wdata;
    end
  end

  // The pipeline never stalls.
  assign busy = 1'b0;

  // Valid bits of the stages.
  logic [8:1] valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else begin
      valid <= {valid[7:1], start & ~busy};
    end
  end

  // Stage 1: zone adjustment with saturation.
  logic signed [33:0] adj_sum;
  logic [31:0]        s1_t;
  logic               s1_clip;

  assign adj_sum = $signed({2'b00, item.seconds_since_epoch})
                 + $signed({{17{zone_offset[16]}}, zone_offset});

  always_ff @(posedge clk) begin
    if (!item.use_local) begin
      s1_t    <= item.seconds_since_epoch;
      s1_clip <= 1'b0;
    end else if (adj_sum[33]) begin
      s1_t    <= '0;
      s1_clip <= 1'b1;
    end else if (adj_sum[32]) begin
      s1_t    <= '1;
      s1_clip <= 1'b1;
    end else begin
      s1_t    <= adj_sum[31:0];
      s1_clip <= 1'b0;
    end
  end

  // Stage 2: total minutes.
  logic [60:0] min_prod;
  logic [31:0] s2_t;
  logic [26:0] s2_m;
  logic        s2_clip;

  assign min_prod = s1_t[31:2] * M_DIV15_30;

  always_ff @(posedge clk) begin
    s2_t    <= s1_t;
    s2_m    <= min_prod[60:K_DIV15_30];
    s2_clip <= s1_clip;
  end

  // Stage 3: seconds and total hours.
  logic [50:0] hour_prod;
  logic [5:0]  s3_sec;
  logic [26:0] s3_m;
  logic [20:0] s3_h;
  logic        s3_clip;

  assign hour_prod = s2_m[26:2] * M_DIV15_25;

  always_ff @(posedge clk) begin
    s3_sec  <= s2_t[5:0] - 6'(s2_m[5:0] * 6'd60);
    s3_m    <= s2_m;
    s3_h    <= hour_prod[49:K_DIV15_25];
    s3_clip <= s2_clip;
  end

  // Stage 4: minutes, total days and the 4-year block.
  logic [36:0] day_prod;
  logic [36:0] quad_prod;
  logic [5:0]  s4_sec;
  logic [5:0]  s4_min;
  logic [20:0] s4_h;
  logic [15:0] s4_days;
  logic [5:0]  s4_quad;
  logic        s4_clip;

  assign day_prod  = s3_h[20:3] * M_DIV3_18;
  assign quad_prod = s3_h[20:3] * M_DIV4383;

  always_ff @(posedge clk) begin
    s4_sec  <= s3_sec;
    s4_min  <= s3_m[5:0] - 6'(s3_h[5:0] * 6'd60);
    s4_h    <= s3_h;
    s4_days <= day_prod[35:K_DIV3_18];
    s4_quad <= quad_prod[36:K_DIV4383];
    s4_clip <= s3_clip;
  end

  // Stage 5: hours within the block, block base year, weekday quotient.
  logic [16:0] wd_sum;
  logic [34:0] wd_prod;
  logic [5:0]  s5_sec;
  logic [5:0]  s5_min;
  logic [15:0] s5_hrem;
  logic [7:0]  s5_base;
  logic [16:0] s5_dw;
  logic [13:0] s5_wq;
  logic        s5_clip;

  assign wd_sum  = {1'b0, s4_days} + 17'(EPOCH_WEEKDAY);
  assign wd_prod = wd_sum * M_DIV7_17;

  always_ff @(posedge clk) begin
    s5_sec  <= s4_sec;
    s5_min  <= s4_min;
    s5_hrem <= s4_h[15:0] - 16'(s4_quad * HOURS_PER_4YEAR);
    s5_base <= BASE_YEAR + {s4_quad, 2'b00};
    s5_dw   <= wd_sum;
    s5_wq   <= wd_prod[33:K_DIV7_17];
    s5_clip <= s4_clip;
  end

  // Stage 6: year within the block and hours into that year; weekday.
  logic [1:0]  yoff;
  logic [15:0] ystart;
  logic [5:0]  s6_sec;
  logic [5:0]  s6_min;
  logic [13:0] s6_hy;
  logic [7:0]  s6_year;
  logic        s6_leap;
  logic [2:0]  s6_wday;
  logic        s6_clip;

  always_comb begin
    priority if (s5_hrem >= YEAR3_START) begin
      yoff   = 2'd3;
      ystart = YEAR3_START;
    end else if (s5_hrem >= YEAR2_START) begin
      yoff   = 2'd2;
      ystart = YEAR2_START;
    end else if (s5_hrem >= YEAR1_START) begin
      yoff   = 2'd1;
      ystart = YEAR1_START;
    end else begin
      yoff   = 2'd0;
      ystart = '0;
    end
  end

  always_ff @(posedge clk) begin
    s6_sec  <= s5_sec;
    s6_min  <= s5_min;
    s6_hy   <= 14'(s5_hrem - ystart);
    s6_year <= s5_base + {6'd0, yoff};
    s6_leap <= (yoff == LEAP_YEAR_SLOT);
    s6_wday <= s5_dw[2:0] - 3'(s5_wq[2:0] * 3'd7);
    s6_clip <= s5_clip;
  end

  // Stage 7: day of year.
  logic [22:0] yday_prod;
  logic [5:0]  s7_sec;
  logic [5:0]  s7_min;
  logic [13:0] s7_hy;
  logic [8:0]  s7_yday;
  logic [7:0]  s7_year;
  logic        s7_leap;
  logic [2:0]  s7_wday;
  logic        s7_clip;

  assign yday_prod = s6_hy[13:3] * M_DIV3_11;

  always_ff @(posedge clk) begin
    s7_sec  <= s6_sec;
    s7_min  <= s6_min;
    s7_hy   <= s6_hy;
    s7_yday <= yday_prod[21:K_DIV3_11];
    s7_year <= s6_year;
    s7_leap <= s6_leap;
    s7_wday <= s6_wday;
    s7_clip <= s6_clip;
  end

  // Stage 8: hour of day, month and day of month into the output register.
  logic       feb29;
  logic [8:0] cday;
  logic [3:0] mon;
  logic [8:0] mday;

  assign feb29 = s7_leap && (s7_yday == FEB29_YDAY);
  assign cday  = (s7_leap && (s7_yday > FEB29_YDAY)) ? s7_yday - 9'd1 : s7_yday;

  // Later months win, so the last start not beyond the day picks the month.
  always_comb begin
    mon = '0;
    for (logic [3:0] i = 4'd1; i < 4'd12; i++) begin
      if (cday >= MONTH_START[i]) begin
        mon = i;
      end
    end
    mday = cday - MONTH_START[mon] + 9'd1;
  end

  always_ff @(posedge clk) begin
    result.second           <= s7_sec;
    result.minute           <= s7_min;
    result.hour             <= s7_hy[4:0] - 5'(s7_yday[4:0] * 5'd24);
    result.day_of_month     <= feb29 ? 5'd29 : mday[4:0];
    result.month            <= feb29 ? 4'd1 : mon;
    result.years_since_1900 <= s7_year;
    result.weekday          <= s7_wday;
    result.day_of_year      <= s7_yday;
    result.range_clipped    <= s7_clip;
  end

  assign done = valid[8];

endmodule
`default_nettype wire
